// ----- src/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Types, codes and helpers shared by the text console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  localparam logic [7:0]  CH_NEWLINE    = 8'h0A;
  localparam logic [7:0]  CH_BACKSPACE  = 8'h08;
  localparam logic [7:0]  DEFAULT_COLOR = 8'h0F;
  localparam logic [15:0] BLANK_SCROLL  = 16'h0020;
  localparam logic [15:0] BLANK_CLEAR   = 16'h0F20;
  localparam logic [15:0] CELL_RESET    = 16'h0000;

  typedef enum logic [1:0] {
    ACT_PUT    = 2'd0,
    ACT_PUT_AT = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  character;
    logic [7:0]  color;
    logic [6:0]  column;
    logic [4:0]  line;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [15:0] cell_word;
    logic        scrolled;
  } out_item_t;

  typedef enum logic [1:0] {
    CUR_NONE,
    CUR_HOME,
    CUR_STEP
  } cur_op_t;

  typedef struct packed {
    cur_op_t     op;
    logic        set;
    logic [6:0]  column;
    logic [4:0]  line;
    logic [7:0]  character;
  } cur_cmd_t;

  // Saturate a requested column to the last column of the screen
  function automatic int sat_column(logic [6:0] column, int cols);
    if (int'(column) >= cols) return cols - 1;
    return int'(column);
  endfunction

  // Saturate a requested row to the bottom row of the screen
  function automatic int sat_line(logic [4:0] line, int rows);
    if (int'(line) >= rows) return rows - 1;
    return int'(line);
  endfunction

endpackage

`default_nettype wire

// ----- src/tcw_stream_if.sv -----
// ----------------------------------------------------------------------------
// tcw_stream_if
// Valid/ready channel carrying one payload of type T per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tcw_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/tcw_cursor.sv -----
// ----------------------------------------------------------------------------
// tcw_cursor
// Cursor unit: holds row, column and cell offset, and works out the next
// position for a put, newline or backspace, including the scroll case.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_cursor #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT,
  localparam int CELLS  = COLUMNS * ROWS,
  localparam int BOTTOM = (ROWS - 1) * COLUMNS,
  localparam int AW     = $clog2(CELLS),
  localparam int OW     = $clog2(CELLS + 1),
  localparam int RW     = $clog2(ROWS + 1),
  localparam int CW     = $clog2(COLUMNS)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tcw_pkg::cur_cmd_t  cmd,
  output logic         [AW-1:0]   pos,
  output logic         [AW-1:0]   start,
  output logic         [AW-1:0]   next_pos,
  output logic                    overflow
);

  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [AW-1:0] off;

  logic [RW-1:0] r0, r1, row_next;
  logic [CW-1:0] c0, c1, col_next;
  logic [OW-1:0] o0, o1;

  always_comb begin
    if (cmd.set) begin
      r0 = RW'(tcw_pkg::sat_line(cmd.line, ROWS));
      c0 = CW'(tcw_pkg::sat_column(cmd.column, COLUMNS));
      o0 = OW'(int'(r0) * COLUMNS + int'(c0));
    end else begin
      r0 = row;
      c0 = col;
      o0 = OW'(off);
    end

    r1 = r0;
    c1 = c0;
    o1 = o0;
    if (cmd.character == tcw_pkg::CH_NEWLINE) begin
      r1 = r0 + RW'(1);
      c1 = '0;
      o1 = o0 - OW'(c0) + OW'(COLUMNS);
    end else if (cmd.character == tcw_pkg::CH_BACKSPACE) begin
      // stop at the first cell
      if (o0 != '0) begin
        o1 = o0 - OW'(1);
        if (c0 == '0) begin
          r1 = r0 - RW'(1);
          c1 = CW'(COLUMNS - 1);
        end else begin
          c1 = c0 - CW'(1);
        end
      end
    end else begin
      o1 = o0 + OW'(1);
      if (c0 == CW'(COLUMNS - 1)) begin
        r1 = r0 + RW'(1);
        c1 = '0;
      end else begin
        c1 = c0 + CW'(1);
      end
    end

    overflow = (r1 == RW'(ROWS));
    if (overflow) begin
      row_next = RW'(ROWS - 1);
      col_next = '0;
      next_pos = AW'(BOTTOM);
    end else begin
      row_next = r1;
      col_next = c1;
      next_pos = AW'(o1);
    end
    start = AW'(o0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
      off <= '0;
    end else begin
      unique case (cmd.op)
        tcw_pkg::CUR_HOME: begin
          row <= '0;
          col <= '0;
          off <= '0;
        end
        tcw_pkg::CUR_STEP: begin
          row <= row_next;
          col <= col_next;
          off <= next_pos;
        end
        tcw_pkg::CUR_NONE: begin
        end
      endcase
    end
  end

  assign pos = off;

endmodule

`default_nettype wire

// ----- src/text_console_writer_core.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text-mode console: screen memory of COLUMNS x ROWS attribute:character
// cells, a cursor, and a sequencer for puts, reads, scroll and clear.
// ----------------------------------------------------------------------------
// One request is handled at a time; each gives one response. A put at the
// cursor or at a position is accepted, then makes at most a single write to
// the screen RAM (none for a newline or backspace). A read adds the wait
// state ST_READ_WAIT for the registered RAM read port. A put that scrolls,
// and a clear, walk the whole screen RAM through its one write port. After
// reset the block zeroes the screen in a sweep before it accepts a request.
// A new request is accepted while the previous response still waits.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  tcw_stream_if.sink   command,
  tcw_stream_if.source response
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int BOTTOM = (ROWS - 1) * COLUMNS;
  localparam int AW     = $clog2(CELLS);
  localparam int KW     = $clog2(CELLS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ_WAIT,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  state_t             state;
  tcw_pkg::in_item_t  item;
  tcw_pkg::out_item_t res;
  tcw_pkg::out_item_t out_data;
  logic               out_valid;
  logic [KW-1:0]      k;
  logic [15:0]        sweep_fill;
  logic               sweep_copy;
  logic               sweep_report;

  logic               acc;
  logic               out_free;
  logic               printable;
  logic [7:0]         attr;
  logic [AW-1:0]      read_idx;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [15:0]        ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [15:0]        ram_rdata;

  tcw_pkg::cur_cmd_t  cur_cmd;
  logic [AW-1:0]      cur_pos;
  logic [AW-1:0]      cur_start;
  logic [AW-1:0]      cur_next;
  logic               cur_overflow;

  logic               fin_go;
  tcw_pkg::out_item_t fin;

  assign command.ready  = (state == ST_IDLE);
  assign acc            = command.valid && command.ready;
  assign out_free       = !out_valid || response.ready;
  assign response.valid = out_valid;
  assign response.data  = out_data;

  assign printable = (item.character != tcw_pkg::CH_NEWLINE) &&
                     (item.character != tcw_pkg::CH_BACKSPACE);
  assign attr      = (item.color == 8'h00) ? tcw_pkg::DEFAULT_COLOR : item.color;
  assign read_idx  = AW'(tcw_pkg::sat_line(item.line, ROWS) * COLUMNS +
                         tcw_pkg::sat_column(item.column, COLUMNS));

  always_comb begin
    cur_cmd.op        = tcw_pkg::CUR_NONE;
    cur_cmd.set       = (item.action == tcw_pkg::ACT_PUT_AT);
    cur_cmd.column    = item.column;
    cur_cmd.line      = item.line;
    cur_cmd.character = item.character;
    if (state == ST_EXEC) begin
      case (item.action) inside
        tcw_pkg::ACT_PUT, tcw_pkg::ACT_PUT_AT: cur_cmd.op = tcw_pkg::CUR_STEP;
        tcw_pkg::ACT_CLEAR:                    cur_cmd.op = tcw_pkg::CUR_HOME;
        default:                               cur_cmd.op = tcw_pkg::CUR_NONE;
      endcase
    end
  end

  // RAM port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_start;
    ram_wdata = {attr, item.character};
    ram_raddr = read_idx;
    if (state == ST_EXEC) begin
      ram_we = ((item.action == tcw_pkg::ACT_PUT) ||
                (item.action == tcw_pkg::ACT_PUT_AT)) && printable;
    end else if (state == ST_SWEEP) begin
      // write address k-1 trails the read; a scroll copies rows up, then fills; a clear or reset only fills
      ram_we    = (k != '0);
      ram_waddr = AW'(k - KW'(1));
      ram_wdata = (sweep_copy && (int'(k) <= BOTTOM)) ? ram_rdata : sweep_fill;
      ram_raddr = (int'(k) < BOTTOM) ? AW'(int'(k) + COLUMNS) : '0;
    end
  end

  always_comb begin
    fin_go = 1'b0;
    fin    = res;
    unique case (state)
      ST_EXEC: begin
        fin_go = ((item.action == tcw_pkg::ACT_PUT) ||
                  (item.action == tcw_pkg::ACT_PUT_AT)) && !cur_overflow;
        fin    = '{cursor_pos: 11'(cur_next), cell_word: 16'h0000, scrolled: 1'b0};
      end
      ST_READ_WAIT: begin
        fin_go = 1'b1;
        fin    = '{cursor_pos: 11'(cur_pos), cell_word: ram_rdata, scrolled: 1'b0};
      end
      ST_FINISH: begin
        fin_go = 1'b1;
      end
      ST_IDLE, ST_SWEEP: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_SWEEP;
      k            <= '0;
      sweep_fill   <= tcw_pkg::CELL_RESET;
      sweep_copy   <= 1'b0;
      sweep_report <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            item  <= command.data;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (item.action) inside
            tcw_pkg::ACT_CLEAR: begin
              k            <= '0;
              sweep_fill   <= tcw_pkg::BLANK_CLEAR;
              sweep_copy   <= 1'b0;
              sweep_report <= 1'b1;
              res          <= '{cursor_pos: 11'd0, cell_word: 16'h0000, scrolled: 1'b0};
              state        <= ST_SWEEP;
            end
            tcw_pkg::ACT_READ: begin
              state <= ST_READ_WAIT;
            end
            default: begin
              if (cur_overflow) begin
                k            <= '0;
                sweep_fill   <= tcw_pkg::BLANK_SCROLL;
                sweep_copy   <= 1'b1;
                sweep_report <= 1'b1;
                res          <= '{cursor_pos: 11'(cur_next), cell_word: 16'h0000,
                                  scrolled: 1'b1};
                state        <= ST_SWEEP;
              end
            end
          endcase
        end
        ST_SWEEP: begin
          if (int'(k) == CELLS) begin
            state <= sweep_report ? ST_FINISH : ST_IDLE;
          end else begin
            k <= k + KW'(1);
          end
        end
        ST_READ_WAIT, ST_FINISH: begin
        end
      endcase
      // hand the response over, or hold it until the output frees
      if (fin_go && out_free) begin
        out_data  <= fin;
        out_valid <= 1'b1;
        state     <= ST_IDLE;
      end else begin
        if (response.ready) begin
          out_valid <= 1'b0;
        end
        if (fin_go) begin
          res   <= fin;
          state <= ST_FINISH;
        end
      end
    end
  end

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cur_cmd),
    .pos      (cur_pos),
    .start    (cur_start),
    .next_pos (cur_next),
    .overflow (cur_overflow)
  );

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ram_we)
    else $error("screen RAM written while idle");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    acc |=> (state == ST_EXEC))
    else $error("accepted request not executed next cycle");

  a_resp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(fin_go))
    else $error("response raised without a finished request");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    int'(cur_pos) < CELLS)
    else $error("cursor beyond last cell");

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (int'(k) <= CELLS))
    else $error("sweep counter past end of screen");

endmodule

`default_nettype wire
